/* sv/hcd_pkg.sv */
// shared types, constants and payload structs of the html character reference decoder
`default_nettype none
package hcd_pkg;

	localparam int DIGIT_LIMIT = 15;
	localparam int HELD_DEPTH  = DIGIT_LIMIT;
	localparam int IDX_W       = $clog2(HELD_DEPTH);
	localparam int LEN_W       = $clog2(HELD_DEPTH + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int ACC_W = 9;
	localparam int MUL_W = ACC_W + 4;
	localparam logic [ACC_W-1:0] ACC_SAT = 9'd256;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PASS_THROUGH = 2'd0,
		REG_UTF8_MODE    = 2'd1,
		REG_NAMED_HACK   = 2'd2
	} hcd_reg_t;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LOW_L = 8'h6C;
	localparam logic [7:0] CH_LOW_T = 8'h74;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_M = 8'h6D;
	localparam logic [7:0] CH_LOW_P = 8'h70;
	localparam logic [7:0] CH_LOW_G = 8'h67;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} hcd_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       from_entity;
		logic       last;
	} hcd_out_t;

	// one emission job: optional '&', then len held bytes, then an optional tail byte
	typedef struct packed {
		logic                        lead;
		logic [LEN_W-1:0]            len;
		logic [HELD_DEPTH-1:0][7:0]  chars;
		logic                        tail_vld;
		logic [7:0]                  tail_char;
		logic                        tail_ent;
	} hcd_cmd_t;

endpackage
`default_nettype wire

/* sv/hcd_front.sv */
// front end: config registers, reference parser and job builder
`default_nettype none
module hcd_front (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [hcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [hcd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                               in_valid,
	input  hcd_pkg::hcd_in_t                  in_data,
	output logic                              in_stall,
	input  wire                               full,
	output logic                              push,
	output hcd_pkg::hcd_cmd_t                 cmd
);

	typedef enum logic [10:0] {
		PH_IDLE       = 11'b00000000001,
		PH_AMP        = 11'b00000000010,
		PH_NUM_FIRST  = 11'b00000000100,
		PH_NUM_DIGITS = 11'b00000001000,
		PH_L1         = 11'b00000010000,
		PH_L2         = 11'b00000100000,
		PH_A1         = 11'b00001000000,
		PH_A2         = 11'b00010000000,
		PH_A3         = 11'b00100000000,
		PH_G1         = 11'b01000000000,
		PH_G2         = 11'b10000000000
	} hcd_phase_t;

	logic pass_through_q;
	logic utf8_mode_q;
	logic named_hack_q;

	hcd_phase_t                    phase_q, nxt_phase;
	logic [hcd_pkg::LEN_W-1:0]     len_q, nxt_len;
	logic                          hex_q, nxt_hex;
	logic [hcd_pkg::ACC_W-1:0]     acc_q, nxt_acc, acc_digit;
	logic [7:0]                    held_q [hcd_pkg::HELD_DEPTH];

	logic                          accept;
	logic                          push_c;
	logic                          wr_en;
	logic                          fail;
	logic                          to_idle;
	logic [7:0]                    b;
	logic                          is_dec, is_hexd, d_ok, is_x, in_range, room;
	logic [3:0]                    dval;
	logic [hcd_pkg::MUL_W-1:0]     acc_mul, acc_sum;

	assign accept   = in_valid && !full;
	assign in_stall = full;
	assign push     = accept && push_c;
	assign b        = in_data.in_byte;

	assign is_dec  = b inside {[8'h30:8'h39]};
	assign is_hexd = hex_q && (b inside {[8'h61:8'h66], [8'h41:8'h46]});
	assign d_ok    = is_dec || is_hexd;
	assign dval    = is_dec ? b[3:0] : (b[3:0] + 4'd9);
	assign is_x    = (b == hcd_pkg::CH_LOW_X) || (b == hcd_pkg::CH_UP_X);
	assign room    = len_q < hcd_pkg::LEN_W'(hcd_pkg::DIGIT_LIMIT);
	assign in_range = acc_q inside {[9'd0:9'd31], [9'd127:9'd255]};

	// times 16 or times 10 as shift and add, then saturate at 256
	assign acc_mul = hex_q ? (hcd_pkg::MUL_W'(acc_q) << 4)
	                       : ((hcd_pkg::MUL_W'(acc_q) << 3) + (hcd_pkg::MUL_W'(acc_q) << 1));
	assign acc_sum = acc_mul + hcd_pkg::MUL_W'(dval);
	assign acc_digit = (acc_q[hcd_pkg::ACC_W-1] || acc_sum > hcd_pkg::MUL_W'(hcd_pkg::ACC_SAT))
	                   ? hcd_pkg::ACC_SAT : acc_sum[hcd_pkg::ACC_W-1:0];

	always_comb begin
		nxt_phase = phase_q;
		nxt_len   = len_q;
		nxt_hex   = hex_q;
		nxt_acc   = acc_q;
		wr_en     = 1'b0;
		push_c    = 1'b0;
		fail      = 1'b0;
		to_idle   = 1'b0;
		cmd.lead      = (phase_q != PH_IDLE);
		cmd.len       = len_q;
		for (int i = 0; i < hcd_pkg::HELD_DEPTH; i++) begin
			cmd.chars[i] = held_q[i];
		end
		cmd.tail_vld  = 1'b0;
		cmd.tail_char = b;
		cmd.tail_ent  = 1'b0;

		if (in_data.end_of_stream) begin
			push_c  = (phase_q != PH_IDLE);
			to_idle = 1'b1;
		end else if (pass_through_q) begin
			push_c       = 1'b1;
			cmd.tail_vld = 1'b1;
			to_idle      = 1'b1;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (b == hcd_pkg::CH_AMP) begin
						nxt_phase = PH_AMP;
					end else begin
						push_c       = 1'b1;
						cmd.tail_vld = 1'b1;
					end
				end
				PH_AMP: begin
					if (b == hcd_pkg::CH_HASH) begin
						nxt_phase = PH_NUM_FIRST;
						nxt_acc   = '0;
						nxt_hex   = 1'b0;
						wr_en     = 1'b1;
					end else if (named_hack_q && b == hcd_pkg::CH_LOW_L) begin
						nxt_phase = PH_L1;
						wr_en     = 1'b1;
					end else if (named_hack_q && b == hcd_pkg::CH_LOW_A) begin
						nxt_phase = PH_A1;
						wr_en     = 1'b1;
					end else if (named_hack_q && b == hcd_pkg::CH_LOW_G) begin
						nxt_phase = PH_G1;
						wr_en     = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end
				PH_L1: begin
					if (b == hcd_pkg::CH_LOW_T) begin
						nxt_phase = PH_L2;
						wr_en     = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end
				PH_A1: begin
					if (b == hcd_pkg::CH_LOW_M) begin
						nxt_phase = PH_A2;
						wr_en     = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end
				PH_A2: begin
					if (b == hcd_pkg::CH_LOW_P) begin
						nxt_phase = PH_A3;
						wr_en     = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end
				PH_G1: begin
					if (b == hcd_pkg::CH_LOW_T) begin
						nxt_phase = PH_G2;
						wr_en     = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end
				PH_L2, PH_A3, PH_G2: begin
					if (b == hcd_pkg::CH_SEMI) begin
						push_c        = 1'b1;
						cmd.lead      = 1'b0;
						cmd.len       = '0;
						cmd.tail_vld  = 1'b1;
						cmd.tail_char = (phase_q == PH_L2) ? hcd_pkg::CH_LT :
						                (phase_q == PH_A3) ? hcd_pkg::CH_AMP : hcd_pkg::CH_GT;
						to_idle       = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end
				PH_NUM_FIRST, PH_NUM_DIGITS: begin
					if (phase_q == PH_NUM_FIRST && is_x) begin
						nxt_hex   = 1'b1;
						nxt_phase = PH_NUM_DIGITS;
						wr_en     = 1'b1;
					end else if (d_ok && room) begin
						nxt_acc   = acc_digit;
						nxt_phase = PH_NUM_DIGITS;
						wr_en     = 1'b1;
					end else if (b == hcd_pkg::CH_SEMI && !utf8_mode_q && in_range) begin
						push_c        = 1'b1;
						cmd.lead      = 1'b0;
						cmd.len       = '0;
						cmd.tail_vld  = 1'b1;
						cmd.tail_char = acc_q[7:0];
						cmd.tail_ent  = 1'b1;
						to_idle       = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end
				default: begin
					to_idle = 1'b1;
				end
			endcase
		end

		// failed match: '&', the held bytes, then this byte, all literal
		if (fail) begin
			push_c       = 1'b1;
			cmd.tail_vld = 1'b1;
			to_idle      = 1'b1;
		end
		if (wr_en) begin
			nxt_len = len_q + hcd_pkg::LEN_W'(1);
		end
		if (to_idle) begin
			nxt_phase = PH_IDLE;
			nxt_len   = '0;
			nxt_hex   = 1'b0;
			nxt_acc   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_through_q <= 1'b0;
			utf8_mode_q    <= 1'b0;
			named_hack_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				hcd_pkg::REG_PASS_THROUGH: pass_through_q <= cfg_data[0];
				hcd_pkg::REG_UTF8_MODE:    utf8_mode_q    <= cfg_data[0];
				hcd_pkg::REG_NAMED_HACK:   named_hack_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q   <= '0;
			hex_q   <= 1'b0;
			acc_q   <= '0;
		end else if (accept) begin
			phase_q <= nxt_phase;
			len_q   <= nxt_len;
			hex_q   <= nxt_hex;
			acc_q   <= nxt_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			held_q[len_q[hcd_pkg::IDX_W-1:0]] <= b;
		end
	end

endmodule
`default_nettype wire

/* sv/hcd_queue.sv */
// small job queue between parser and emitter
`default_nettype none
module hcd_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  hcd_pkg::hcd_cmd_t    push_cmd,
	output logic                 full,
	input  wire                  pop,
	output logic                 head_valid,
	output hcd_pkg::hcd_cmd_t    head_cmd
);

	hcd_pkg::hcd_cmd_t              entry_q [hcd_pkg::QUEUE_DEPTH];
	logic [hcd_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [hcd_pkg::QCNT_W-1:0]     count_q;

	assign full       = (count_q == hcd_pkg::QCNT_W'(hcd_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];

	function automatic logic [hcd_pkg::QPTR_W-1:0] ptr_inc(input logic [hcd_pkg::QPTR_W-1:0] p);
		ptr_inc = (p == hcd_pkg::QPTR_W'(hcd_pkg::QUEUE_DEPTH - 1)) ? '0
		          : p + hcd_pkg::QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + hcd_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - hcd_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

/* sv/hcd_back.sv */
// back end: walks one job per queue entry and drives the output register
`default_nettype none
module hcd_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  head_valid,
	input  hcd_pkg::hcd_cmd_t    head_cmd,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_stall,
	output hcd_pkg::hcd_out_t    out_data
);

	typedef enum logic [2:0] {
		SEG_AMP  = 3'b001,
		SEG_BODY = 3'b010,
		SEG_TAIL = 3'b100
	} hcd_seg_t;

	hcd_seg_t                    seg_q, nxt_seg;
	logic [hcd_pkg::IDX_W-1:0]   idx_q, nxt_idx;
	logic                        out_valid_q;
	hcd_pkg::hcd_out_t           out_q, beat;
	logic                        load;
	logic                        body_end;

	assign load      = head_valid && (!out_valid_q || !out_stall);
	assign pop       = load && beat.last;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign body_end  = (hcd_pkg::LEN_W'(idx_q) + hcd_pkg::LEN_W'(1)) == head_cmd.len;

	always_comb begin
		nxt_seg          = seg_q;
		nxt_idx          = idx_q;
		beat.out_char    = head_cmd.tail_char;
		beat.from_entity = head_cmd.tail_ent;
		beat.last        = 1'b1;
		case (seg_q)
			SEG_AMP: begin
				if (head_cmd.lead) begin
					beat.out_char    = hcd_pkg::CH_AMP;
					beat.from_entity = 1'b0;
					beat.last        = (head_cmd.len == '0) && !head_cmd.tail_vld;
					nxt_idx          = '0;
					nxt_seg          = (head_cmd.len != '0) ? SEG_BODY : SEG_TAIL;
				end
			end
			SEG_BODY: begin
				beat.out_char    = head_cmd.chars[idx_q];
				beat.from_entity = 1'b0;
				beat.last        = body_end && !head_cmd.tail_vld;
				if (body_end) begin
					nxt_seg = SEG_TAIL;
				end else begin
					nxt_idx = idx_q + hcd_pkg::IDX_W'(1);
				end
			end
			SEG_TAIL: ;
			default: ;
		endcase
		if (beat.last) begin
			nxt_seg = SEG_AMP;
			nxt_idx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			seg_q       <= SEG_AMP;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			seg_q       <= nxt_seg;
			idx_q       <= nxt_idx;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= beat;
		end
	end

endmodule
`default_nettype wire

/* sv/html_char_reference_decoder.sv */
// top level of the html character reference decoder (numeric, and lt, amp, gt when named_hack is set)
//
// Input channel: in_valid / in_stall / in_data carries one text byte per beat, or an
// end-of-stream marker that flushes any partly read reference literally.
// Output channel: out_valid / out_stall / out_data gives one byte per beat; last marks
// the final beat caused by one input beat. Inputs that complete nothing yield no beat.
// Config: cfg_we writes cfg_data into register cfg_index (pass_through, utf8_mode,
// named_hack_enable); write only while the block is idle.
// The parser pushes a beat's job into the queue as the beat is accepted; the emitter
// loads the job's first result into the output register once it reaches the queue head.
// Throughput: one input byte per cycle while each yields at most one result, out_stall low.
// A failed or flushed reference makes the emitter send up to 17 beats, one per cycle while
// out_stall is low; the two-entry job queue absorbs this and in_stall rises when it is full.
// Reset: parser idle, registers zero, queue empty, out_valid low.
// A stalled output holds its beat; the queue then fills and stalls the input side.
`default_nettype none
module html_char_reference_decoder (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [hcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [hcd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  hcd_pkg::hcd_in_t                  in_data,
	output logic                              out_valid,
	input  wire                               out_stall,
	output hcd_pkg::hcd_out_t                 out_data
);

	logic                  q_full;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_head_valid;
	hcd_pkg::hcd_cmd_t     q_push_cmd;
	hcd_pkg::hcd_cmd_t     q_head_cmd;

	hcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.full      (q_full),
		.push      (q_push),
		.cmd       (q_push_cmd)
	);

	hcd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_cmd   (q_head_cmd)
	);

	hcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_cmd   (q_head_cmd),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

/* sv/hcd_checker.sv */
// port-level checks of the decoder and their binding to the top level
`default_nettype none
module hcd_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  out_valid,
	input wire                  out_stall,
	input hcd_pkg::hcd_out_t    out_data
);

	// a stalled beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

	// a decoded reference is always the only result of its input
	a_entity_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.from_entity |-> out_data.last)
		else $error("decoded byte not marked last");

	a_entity_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.from_entity |->
			(out_data.out_char < 8'd32) || (out_data.out_char >= 8'd127))
		else $error("decoded byte outside control and high ranges");

endmodule

bind html_char_reference_decoder hcd_checker u_hcd_checker (.*);
`default_nettype wire

/* tb/tb_html_char_reference_decoder.sv */
// self-checking testbench for the html character reference decoder
`timescale 1ns / 100ps

module tb_html_char_reference_decoder;

	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int BLOCK_BEATS     = 32;
	localparam int NUM_BLOCKS      = 6;

	localparam int CTRL_END   = 32;
	localparam int HIGH_START = 127;
	localparam int HIGH_END   = 255;

	localparam logic [7:0] CH_DIG0 = "0";
	localparam logic [7:0] CH_DIG9 = "9";
	localparam logic [7:0] CH_LA   = "a";
	localparam logic [7:0] CH_LF   = "f";
	localparam logic [7:0] CH_UA   = "A";
	localparam logic [7:0] CH_UF   = "F";
	localparam logic [7:0] CH_CASE = 8'h20;

	localparam hcd_pkg::hcd_out_t NO_BEAT = '0;

	typedef enum logic [3:0] {
		PARSE_IDLE, PARSE_AMP, PARSE_HASH, PARSE_DIGITS,
		NM_L, NM_LT, NM_A, NM_AM, NM_AMP, NM_G, NM_GT
	} parse_t;

	typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		hcd_pkg::hcd_reg_t  sel;
		logic               val;
		hcd_pkg::hcd_in_t   beat;
		logic               typed;
		logic               typed_cnt;
		hcd_pkg::hcd_out_t  typed_res;
	} plan_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [hcd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [hcd_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	hcd_pkg::hcd_in_t               in_data;
	logic                           out_valid;
	logic                           out_stall;
	hcd_pkg::hcd_out_t              out_data;

	// expectation typed into the plan travels with the beat
	logic              typed_on;
	logic              typed_cnt;
	hcd_pkg::hcd_out_t typed_res;

	// decoder shadow state and register copies
	parse_t     ph;
	logic [7:0] held [hcd_pkg::DIGIT_LIMIT];
	int         held_n;
	logic       hex_ref;
	int         acc;
	logic       c_pass, c_utf8, c_named;

	hcd_pkg::hcd_out_t want_chars[$];
	plan_row_t         plan[$];
	hcd_pkg::hcd_out_t want, junk;
	int        mark;
	int        n_err = 0;
	int        quiet = 0;
	int        beats_sent = 0;
	int        tx_idle_pct;
	int        rx_idle_pct;
	logic      hold_ask, hold_seen;

	html_char_reference_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(string what);
		$display("mismatch: %s", what);
		n_err++;
	endtask

	function automatic void put_char(logic [7:0] ch, logic ent);
		hcd_pkg::hcd_out_t r;
		r.out_char    = ch;
		r.from_entity = ent;
		r.last        = 1'b0;
		want_chars.push_back(r);
	endfunction

	function automatic void clear_ref();
		ph      = PARSE_IDLE;
		held_n  = 0;
		hex_ref = 1'b0;
		acc     = 0;
	endfunction

	// re-emit the '&' and everything read after it
	function automatic void spill_pending();
		int i;
		if (ph != PARSE_IDLE) begin
			put_char(hcd_pkg::CH_AMP, 1'b0);
			case (ph)
				PARSE_HASH, PARSE_DIGITS: begin
					put_char(hcd_pkg::CH_HASH, 1'b0);
					for (i = 0; i < held_n; i++)
						put_char(held[i], 1'b0);
				end
				NM_L: put_char(hcd_pkg::CH_LOW_L, 1'b0);
				NM_LT: begin
					put_char(hcd_pkg::CH_LOW_L, 1'b0);
					put_char(hcd_pkg::CH_LOW_T, 1'b0);
				end
				NM_A: put_char(hcd_pkg::CH_LOW_A, 1'b0);
				NM_AM: begin
					put_char(hcd_pkg::CH_LOW_A, 1'b0);
					put_char(hcd_pkg::CH_LOW_M, 1'b0);
				end
				NM_AMP: begin
					put_char(hcd_pkg::CH_LOW_A, 1'b0);
					put_char(hcd_pkg::CH_LOW_M, 1'b0);
					put_char(hcd_pkg::CH_LOW_P, 1'b0);
				end
				NM_G: put_char(hcd_pkg::CH_LOW_G, 1'b0);
				NM_GT: begin
					put_char(hcd_pkg::CH_LOW_G, 1'b0);
					put_char(hcd_pkg::CH_LOW_T, 1'b0);
				end
				default: ;
			endcase
		end
		clear_ref();
	endfunction

	function automatic void named_next(logic [7:0] b, logic [7:0] match, parse_t nxt,
		logic [7:0] repl);
		if (b == match) begin
			if (nxt == PARSE_IDLE) begin
				put_char(repl, 1'b0);
				clear_ref();
			end else begin
				ph = nxt;
			end
		end else begin
			spill_pending();
			put_char(b, 1'b0);
		end
	endfunction

	function automatic int digit_val(logic [7:0] b, logic hx);
		if (b >= CH_DIG0 && b <= CH_DIG9)
			return int'(b - CH_DIG0);
		if (hx && b >= CH_LA && b <= CH_LF)
			return int'(b - CH_LA) + 10;
		if (hx && b >= CH_UA && b <= CH_UF)
			return int'(b - CH_UA) + 10;
		return -1;
	endfunction

	function automatic void decode_ref_byte(hcd_pkg::hcd_in_t x);
		logic [7:0]        b;
		int                d, v, first;
		hcd_pkg::hcd_out_t r;
		b     = x.in_byte;
		first = want_chars.size();
		if (x.end_of_stream) begin
			spill_pending();
		end else if (c_pass) begin
			spill_pending();
			put_char(b, 1'b0);
		end else begin
			case (ph)
				PARSE_AMP: begin
					if (b == hcd_pkg::CH_HASH) begin
						ph      = PARSE_HASH;
						held_n  = 0;
						acc     = 0;
						hex_ref = 1'b0;
					end else if (c_named && b == hcd_pkg::CH_LOW_L) begin
						ph = NM_L;
					end else if (c_named && b == hcd_pkg::CH_LOW_A) begin
						ph = NM_A;
					end else if (c_named && b == hcd_pkg::CH_LOW_G) begin
						ph = NM_G;
					end else begin
						spill_pending();
						put_char(b, 1'b0);
					end
				end
				NM_L:   named_next(b, hcd_pkg::CH_LOW_T, NM_LT, 8'h00);
				NM_LT:  named_next(b, hcd_pkg::CH_SEMI, PARSE_IDLE, hcd_pkg::CH_LT);
				NM_A:   named_next(b, hcd_pkg::CH_LOW_M, NM_AM, 8'h00);
				NM_AM:  named_next(b, hcd_pkg::CH_LOW_P, NM_AMP, 8'h00);
				NM_AMP: named_next(b, hcd_pkg::CH_SEMI, PARSE_IDLE, hcd_pkg::CH_AMP);
				NM_G:   named_next(b, hcd_pkg::CH_LOW_T, NM_GT, 8'h00);
				NM_GT:  named_next(b, hcd_pkg::CH_SEMI, PARSE_IDLE, hcd_pkg::CH_GT);
				PARSE_HASH, PARSE_DIGITS: begin
					if (held_n < hcd_pkg::DIGIT_LIMIT) begin
						held[held_n] = b;
						held_n++;
					end
					if (ph == PARSE_HASH &&
						(b == hcd_pkg::CH_LOW_X || b == hcd_pkg::CH_UP_X)) begin
						hex_ref = 1'b1;
						ph      = PARSE_DIGITS;
					end else begin
						ph = PARSE_DIGITS;
						d  = digit_val(b, hex_ref);
						if (d >= 0 && held_n < hcd_pkg::DIGIT_LIMIT) begin
							v   = hex_ref ? acc * 16 + d : acc * 10 + d;
							acc = (acc >= int'(hcd_pkg::ACC_SAT) || v > int'(hcd_pkg::ACC_SAT))
								? int'(hcd_pkg::ACC_SAT) : v;
						end else if (b == hcd_pkg::CH_SEMI && !c_utf8 &&
							(acc < CTRL_END || (acc >= HIGH_START && acc <= HIGH_END))) begin
							put_char(acc[7:0], 1'b1);
							clear_ref();
						end else begin
							spill_pending();
						end
					end
				end
				default: begin
					clear_ref();
					if (b == hcd_pkg::CH_AMP)
						ph = PARSE_AMP;
					else
						put_char(b, 1'b0);
				end
			endcase
		end
		if (want_chars.size() > first) begin
			r      = want_chars.pop_back();
			r.last = 1'b1;
			want_chars.push_back(r);
		end
	endfunction

	// output check first, then the new input beat
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (want_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected output beat %h", out_data));
			end else begin
				want = want_chars.pop_front();
				if (out_data.out_char !== want.out_char)
					report_mismatch($sformatf("out_char got %h want %h",
						out_data.out_char, want.out_char));
				if (out_data.from_entity !== want.from_entity)
					report_mismatch($sformatf("from_entity got %b want %b for char %h",
						out_data.from_entity, want.from_entity, want.out_char));
				if (out_data.last !== want.last)
					report_mismatch($sformatf("last got %b want %b for char %h",
						out_data.last, want.last, want.out_char));
			end
		end
		if (in_valid && !in_stall) begin
			mark = want_chars.size();
			decode_ref_byte(in_data);
			if (typed_on) begin
				while (want_chars.size() > mark)
					junk = want_chars.pop_back();
				if (typed_cnt)
					want_chars.push_back(typed_res);
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
	end

	initial begin
		wait (quiet >= WATCHDOG_CYCLES);
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	task automatic send_beat(hcd_pkg::hcd_in_t x, logic ty, logic cnt,
		hcd_pkg::hcd_out_t res);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		in_data   <= x;
		typed_on  <= ty;
		typed_cnt <= cnt;
		typed_res <= res;
		do
			@(posedge clk);
		while (in_stall);
		beats_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (want_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(hcd_pkg::hcd_reg_t sel, logic val);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (sel)
			hcd_pkg::REG_PASS_THROUGH: c_pass  = val;
			hcd_pkg::REG_UTF8_MODE:    c_utf8  = val;
			hcd_pkg::REG_NAMED_HACK:   c_named = val;
			default: ;
		endcase
	endtask

	function automatic hcd_pkg::hcd_out_t sole_beat(logic [7:0] ch, logic ent);
		hcd_pkg::hcd_out_t r;
		r.out_char    = ch;
		r.from_entity = ent;
		r.last        = 1'b1;
		return r;
	endfunction

	function automatic void add_beat(logic [7:0] b, logic eos, logic ty, logic cnt,
		hcd_pkg::hcd_out_t res);
		plan_row_t p;
		p                    = '0;
		p.kind               = ROW_BEAT;
		p.beat.in_byte       = b;
		p.beat.end_of_stream = eos;
		p.typed              = ty;
		p.typed_cnt          = cnt;
		p.typed_res          = res;
		plan.push_back(p);
	endfunction

	function automatic void add_reg(hcd_pkg::hcd_reg_t sel, logic val);
		plan_row_t p;
		p      = '0;
		p.kind = ROW_REG;
		p.sel  = sel;
		p.val  = val;
		plan.push_back(p);
	endfunction

	// one random word: mostly well-formed references, some noise and broken ones
	task automatic send_word();
		logic [7:0]       w[$];
		string            digits;
		int               kind, val, pad, cut, i;
		logic [7:0]       c;
		logic             eos_now;
		hcd_pkg::hcd_in_t x;
		kind    = $urandom_range(0, 9);
		eos_now = 1'b0;
		if (kind <= 4) begin
			case ($urandom_range(0, 3))
				0: val = $urandom_range(0, CTRL_END - 1);
				1: val = $urandom_range(HIGH_START, HIGH_END);
				2: val = $urandom_range(CTRL_END, HIGH_START - 1);
				default: val = $urandom_range(256, 70000);
			endcase
			pad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 2);
			w.push_back(hcd_pkg::CH_AMP);
			w.push_back(hcd_pkg::CH_HASH);
			if (kind >= 3) begin
				w.push_back($urandom_range(0, 1) ? hcd_pkg::CH_LOW_X : hcd_pkg::CH_UP_X);
				digits = $sformatf("%0h", val);
			end else begin
				digits = $sformatf("%0d", val);
			end
			if ($urandom_range(0, 9) == 0) begin
				digits = "";
				pad    = 0;
			end
			repeat (pad) w.push_back(CH_DIG0);
			for (i = 0; i < digits.len(); i++) begin
				c = digits[i];
				// flip the ascii case bit on some hex letters
				if (c >= CH_LA && $urandom_range(0, 1))
					c = c - CH_CASE;
				w.push_back(c);
			end
			w.push_back(hcd_pkg::CH_SEMI);
		end else if (kind <= 6) begin
			w.push_back(hcd_pkg::CH_AMP);
			case ($urandom_range(0, 2))
				0: begin
					w.push_back(hcd_pkg::CH_LOW_L);
					w.push_back(hcd_pkg::CH_LOW_T);
				end
				1: begin
					w.push_back(hcd_pkg::CH_LOW_A);
					w.push_back(hcd_pkg::CH_LOW_M);
					w.push_back(hcd_pkg::CH_LOW_P);
				end
				default: begin
					w.push_back(hcd_pkg::CH_LOW_G);
					w.push_back(hcd_pkg::CH_LOW_T);
				end
			endcase
			w.push_back(hcd_pkg::CH_SEMI);
		end else begin
			repeat ($urandom_range(1, 4))
				w.push_back(($urandom_range(0, 7) == 0) ? hcd_pkg::CH_AMP
					: 8'($urandom_range(0, 255)));
		end
		if (w.size() > 1 && $urandom_range(0, 5) == 0) begin
			cut = $urandom_range(1, w.size() - 1);
			while (w.size() > cut)
				c = w.pop_back();
			if ($urandom_range(0, 1))
				eos_now = 1'b1;
			else
				w.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 9) == 0)
			eos_now = 1'b1;
		for (i = 0; i < w.size(); i++) begin
			x.in_byte       = w[i];
			x.end_of_stream = 1'b0;
			send_beat(x, 1'b0, 1'b0, NO_BEAT);
		end
		if (eos_now) begin
			x.in_byte       = 8'($urandom_range(0, 255));
			x.end_of_stream = 1'b1;
			send_beat(x, 1'b0, 1'b0, NO_BEAT);
		end
	endtask

	initial begin
		int   blk, stop_at, i;
		logic pt, u8, nh;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		typed_on    = 1'b0;
		typed_cnt   = 1'b0;
		typed_res   = '0;
		hold_ask    = 1'b0;
		tx_idle_pct = 38;
		rx_idle_pct = 80;
		c_pass      = 1'b0;
		c_utf8      = 1'b0;
		c_named     = 1'b0;
		clear_ref();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte extremes with reset settings
		add_beat(8'h00, 1'b0, 1'b1, 1'b1, sole_beat(8'h00, 1'b0));
		add_beat(8'hFF, 1'b0, 1'b1, 1'b1, sole_beat(8'hFF, 1'b0));
		// empty decimal number decodes to zero
		add_beat(hcd_pkg::CH_AMP, 1'b0, 1'b1, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_HASH, 1'b0, 1'b1, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_SEMI, 1'b0, 1'b1, 1'b1, sole_beat(8'h00, 1'b1));
		// empty hex number
		add_beat(hcd_pkg::CH_AMP, 1'b0, 1'b1, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_HASH, 1'b0, 1'b1, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_UP_X, 1'b0, 1'b1, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_SEMI, 1'b0, 1'b1, 1'b1, sole_beat(8'h00, 1'b1));
		// printable value is out of range, echoed literally
		add_beat(hcd_pkg::CH_AMP, 1'b0, 1'b0, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_HASH, 1'b0, 1'b0, 1'b0, NO_BEAT);
		add_beat(CH_DIG0 + 8'd6, 1'b0, 1'b0, 1'b0, NO_BEAT);
		add_beat(CH_DIG0 + 8'd5, 1'b0, 1'b0, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_SEMI, 1'b0, 1'b0, 1'b0, NO_BEAT);
		// end of stream with nothing held
		add_beat(8'hA5, 1'b1, 1'b1, 1'b0, NO_BEAT);
		add_reg(hcd_pkg::REG_NAMED_HACK, 1'b1);
		add_reg(hcd_pkg::REG_UTF8_MODE, 1'b1);
		add_beat(hcd_pkg::CH_AMP, 1'b0, 1'b1, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_LOW_G, 1'b0, 1'b1, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_LOW_T, 1'b0, 1'b1, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_SEMI, 1'b0, 1'b1, 1'b1, sole_beat(hcd_pkg::CH_GT, 1'b0));
		// utf8 mode rejects a control value
		add_beat(hcd_pkg::CH_AMP, 1'b0, 1'b0, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_HASH, 1'b0, 1'b0, 1'b0, NO_BEAT);
		add_beat(CH_DIG0 + 8'd9, 1'b0, 1'b0, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_SEMI, 1'b0, 1'b0, 1'b0, NO_BEAT);
		// end of stream inside a named reference
		add_beat(hcd_pkg::CH_AMP, 1'b0, 1'b0, 1'b0, NO_BEAT);
		add_beat(hcd_pkg::CH_LOW_A, 1'b0, 1'b0, 1'b0, NO_BEAT);
		add_beat(8'h5A, 1'b1, 1'b0, 1'b0, NO_BEAT);
		// pass-through switched on with '&' held
		add_beat(hcd_pkg::CH_AMP, 1'b0, 1'b0, 1'b0, NO_BEAT);
		add_reg(hcd_pkg::REG_PASS_THROUGH, 1'b1);
		add_beat(8'h5A, 1'b0, 1'b0, 1'b0, NO_BEAT);

		for (i = 0; i < plan.size(); i++) begin
			if (plan[i].kind == ROW_REG)
				write_reg(plan[i].sel, plan[i].val);
			else
				send_beat(plan[i].beat, plan[i].typed, plan[i].typed_cnt, plan[i].typed_res);
		end

		for (blk = 0; blk < NUM_BLOCKS; blk++) begin
			case (blk)
				0: {pt, u8, nh} = 3'b000;
				1: {pt, u8, nh} = 3'b111;
				2: {pt, u8, nh} = 3'b001;
				4: {pt, u8, nh} = 3'b011;
				default: {pt, u8, nh} = {$urandom_range(0, 3) == 0, $urandom_range(0, 1) == 1,
					$urandom_range(0, 1) == 1};
			endcase
			write_reg(hcd_pkg::REG_PASS_THROUGH, pt);
			write_reg(hcd_pkg::REG_UTF8_MODE, u8);
			write_reg(hcd_pkg::REG_NAMED_HACK, nh);
			if (blk < 2) begin
				tx_idle_pct = 38;
				rx_idle_pct <= 80;
			end else if (blk < 4) begin
				tx_idle_pct = 80;
				rx_idle_pct <= 38;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			// long receiver hold-off while the sender keeps pushing
			if (blk == 4)
				hold_ask <= ~hold_ask;
			stop_at = beats_sent + BLOCK_BEATS;
			while (beats_sent < stop_at)
				send_word();
		end

		wait_idle();
		if (n_err == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
sv/hcd_pkg.sv
sv/hcd_front.sv
sv/hcd_queue.sv
sv/hcd_back.sv
sv/html_char_reference_decoder.sv
sv/hcd_checker.sv
tb/tb_html_char_reference_decoder.sv
